// ===== hdl/tprt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprt_pkg - shared types and constants of the pattern row transcoder
// Slot layout, commit and cell-control bundles, parser phase codes.
// ----------------------------------------------------------------------------
package tprt_pkg;

  localparam int unsigned CntW = 6;

  localparam logic [6:0] NoteKeyOff = 7'd97;
  localparam logic [4:0] BitsNoteInst = 5'h03;
  localparam logic [4:0] BitsVol = 5'h04;
  localparam logic [4:0] BitsEff = 5'h18;
  localparam logic [7:0] PackedBase = 8'h80;

  typedef struct packed {
    logic [4:0] bits;
    logic [6:0] note;
    logic [6:0] inst;
    logic [7:0] vol;
    logic [7:0] eff;
    logic [7:0] par;
  } slot_t;

  localparam slot_t SlotEmpty = '0;

  typedef struct packed {
    logic       valid;
    logic [4:0] chan;
    slot_t      slot;
  } commit_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef enum logic [7:0] {
    PhFollow = 8'b0000_0001,
    PhNote   = 8'b0000_0010,
    PhInst   = 8'b0000_0100,
    PhInstX  = 8'b0000_1000,
    PhInstHi = 8'b0001_0000,
    PhVol    = 8'b0010_0000,
    PhEff    = 8'b0100_0000,
    PhParam  = 8'b1000_0000
  } phase_e;

endpackage

// ===== hdl/tprt_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprt_parser - stream byte parser
// Walks the follow/note/instrument/volume/effect phases and hands a finished
// channel entry to the row store; flags a zero follow byte as row end.
// ----------------------------------------------------------------------------
module tprt_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  input  logic [7:0]        byte_i,
  output tprt_pkg::commit_t commit_o,
  output logic              row_end_o
);
  import tprt_pkg::*;

  phase_e     phase_q, phase_d;
  logic [4:0] chan_q, chan_d;
  logic [2:0] flags_q, flags_d;
  logic [6:0] note_q, note_d;
  logic [6:0] inst_q, inst_d;
  logic [7:0] vol_q, vol_d;
  logic [7:0] eff_q, eff_d;
  logic       commit;
  logic [7:0] par;
  logic [6:0] note_raw;

  assign note_raw = byte_i[6:0];

  always_comb begin
    phase_d   = phase_q;
    chan_d    = chan_q;
    flags_d   = flags_q;
    note_d    = note_q;
    inst_d    = inst_q;
    vol_d     = vol_q;
    eff_d     = eff_q;
    commit    = 1'b0;
    par       = 8'h00;
    row_end_o = 1'b0;
    if (byte_valid_i) begin
      case (phase_q)
        PhFollow: begin
          if (byte_i == 8'h00) begin
            row_end_o = 1'b1;
          end else begin
            chan_d  = byte_i[4:0];
            flags_d = byte_i[7:5];
            note_d  = '0;
            inst_d  = '0;
            vol_d   = '0;
            eff_d   = '0;
            if (byte_i[5]) phase_d = PhNote;
            else if (byte_i[6]) phase_d = PhVol;
            else if (byte_i[7]) phase_d = PhEff;
            else commit = 1'b1;
          end
        end
        PhNote: begin
          note_d  = (note_raw == 7'd0 || note_raw > NoteKeyOff) ? NoteKeyOff : note_raw;
          phase_d = byte_i[7] ? PhInstX : PhInst;
        end
        PhInst, PhInstHi: begin
          if (phase_q == PhInst) inst_d = byte_i[6:0];
          if (flags_q[1]) phase_d = PhVol;
          else if (flags_q[2]) phase_d = PhEff;
          else commit = 1'b1;
        end
        PhInstX: begin
          inst_d  = byte_i[6:0];
          phase_d = PhInstHi;
        end
        PhVol: begin
          vol_d = byte_i;
          if (flags_q[2]) phase_d = PhEff;
          else commit = 1'b1;
        end
        PhEff: begin
          eff_d   = byte_i;
          phase_d = PhParam;
        end
        PhParam: begin
          par    = byte_i;
          commit = 1'b1;
        end
        default: begin
          phase_d = PhFollow;
        end
      endcase
      if (commit) phase_d = PhFollow;
    end
  end

  // Build the slot from the values as they stand after this byte.
  always_comb begin
    commit_o       = '0;
    commit_o.valid = commit;
    commit_o.chan  = chan_d;
    if (flags_d[0]) begin
      commit_o.slot.bits = commit_o.slot.bits | BitsNoteInst;
      commit_o.slot.note = note_d;
      commit_o.slot.inst = inst_d;
    end
    if (flags_d[1]) begin
      commit_o.slot.bits = commit_o.slot.bits | BitsVol;
      commit_o.slot.vol  = vol_d;
    end
    if (flags_d[2]) begin
      commit_o.slot.bits = commit_o.slot.bits | BitsEff;
      commit_o.slot.eff  = eff_d;
      commit_o.slot.par  = par;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFollow;
      chan_q  <= '0;
      flags_q <= '0;
      note_q  <= '0;
      inst_q  <= '0;
      vol_q   <= '0;
      eff_q   <= '0;
    end else begin
      phase_q <= phase_d;
      chan_q  <= chan_d;
      flags_q <= flags_d;
      note_q  <= note_d;
      inst_q  <= inst_d;
      vol_q   <= vol_d;
      eff_q   <= eff_d;
    end
  end

endmodule

// ===== hdl/tprt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprt_cell - one channel slot of the row store
// Takes a commit addressed to its channel, shifts from its upper neighbor
// during a row flush, and empties on clear.
// ----------------------------------------------------------------------------
module tprt_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tprt_pkg::cell_ctrl_t ctrl_i,
  input  tprt_pkg::commit_t    commit_i,
  input  tprt_pkg::slot_t      next_i,
  output tprt_pkg::slot_t      slot_o
);
  import tprt_pkg::*;

  slot_t slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.clear) begin
      slot_d = SlotEmpty;
    end else if (ctrl_i.shift) begin
      slot_d = next_i;
    end else if (commit_i.valid && commit_i.chan == 5'(CellIdx)) begin
      slot_d = commit_i.slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= SlotEmpty;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

// ===== hdl/tracker_pattern_row_transcoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_pattern_row_transcoder - compressed pattern row to packed entries
// Parses a compressed tracker pattern stream and emits one packed word per
// configured channel at each row end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one stream byte per word (in_valid_i / in_stall_o).
//   While parsing, a byte is taken every cycle. A zero follow byte ends the
//   row: the store then flushes one packed word per channel 0..count-1,
//   one word per cycle unless the output stalls, out of cell 0 of the cell
//   chain. The input is stalled during the flush. The row end byte sets the
//   flush flag, and the flush then loads the first word into the output
//   register. A count of zero just clears the store.
//   Output channel: out_valid_o / out_stall_i, one registered word. A stall
//   holds the word and freezes the chain; the flush resumes when released.
//   cfg_we_i / cfg_wdata_i write channel_count (saturated to MAX_CHANNELS);
//   write it only while idle.
//   Reset: parser expects a follow byte, all slots empty, count = 8 (MAX_CHANNELS if smaller).
// ----------------------------------------------------------------------------
module tracker_pattern_row_transcoder #(
  parameter int unsigned MAX_CHANNELS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] stream_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [4:0] channel_index_o,
  output logic [7:0] packed_flag_o,
  output logic [6:0] note_value_o,
  output logic [6:0] instrument_value_o,
  output logic [7:0] volume_value_o,
  output logic [7:0] effect_type_o,
  output logic [7:0] effect_param_o,
  output logic       last_in_row_o
);
  import tprt_pkg::*;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_CHANNELS);
  localparam logic [CntW-1:0] ResetCnt = (MAX_CHANNELS < 8) ? MaxCnt : CntW'(8);

  logic            in_accept;
  commit_t         commit;
  logic            row_end;
  cell_ctrl_t      ctrl;
  slot_t           chain [MAX_CHANNELS];

  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] row_cnt_q;
  logic            flush_q;
  logic [4:0]      idx_q;
  logic            step;
  logic            last;

  logic            out_valid_q;
  logic [4:0]      out_idx_q;
  slot_t           out_slot_q;
  logic            out_last_q;

  // Take no byte while the row is flushing.
  assign in_stall_o = flush_q;
  assign in_accept  = in_valid_i && !flush_q;

  tprt_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_accept),
    .byte_i       (stream_byte_i),
    .commit_o     (commit),
    .row_end_o    (row_end)
  );

  // Chain of slots: cell k loads from cell k+1 on shift; the top takes empty.
  for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_cell
    slot_t next_slot;
    if (k == MAX_CHANNELS - 1) begin : g_top
      assign next_slot = SlotEmpty;
    end else begin : g_mid
      assign next_slot = chain[k+1];
    end
    tprt_cell #(
      .CellIdx (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .commit_i (commit),
      .next_i   (next_slot),
      .slot_o   (chain[k])
    );
  end

  // Advance the flush whenever the output register is free or being taken.
  assign step = flush_q && (!out_valid_q || !out_stall_i);
  assign last = ({1'b0, idx_q} + CntW'(1)) == row_cnt_q;

  always_comb begin
    ctrl       = '0;
    ctrl.shift = step && !last;
    ctrl.clear = (step && last) || (row_end && cnt_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= ResetCnt;
      row_cnt_q <= '0;
      flush_q   <= 1'b0;
      idx_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        cnt_q <= (cfg_wdata_i > MaxCnt) ? MaxCnt : cfg_wdata_i;
      end
      if (row_end && cnt_q != '0) begin
        flush_q   <= 1'b1;
        row_cnt_q <= cnt_q;
        idx_q     <= '0;
      end else if (step) begin
        if (last) flush_q <= 1'b0;
        else idx_q <= idx_q + 5'd1;
      end
    end
  end

  // Output register: hold while stalled, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_idx_q  <= idx_q;
      out_slot_q <= chain[0];
      out_last_q <= last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign channel_index_o    = out_idx_q;
  assign packed_flag_o      = PackedBase | {3'b000, out_slot_q.bits};
  assign note_value_o       = out_slot_q.note;
  assign instrument_value_o = out_slot_q.inst;
  assign volume_value_o     = out_slot_q.vol;
  assign effect_type_o      = out_slot_q.eff;
  assign effect_param_o     = out_slot_q.par;
  assign last_in_row_o      = out_last_q;

  // A word that is not the row's last means the flush is still running.
  a_nonlast_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_in_row_o |-> flush_q)
    else $error("non-last word shown with no flush in progress");

  // The flush index stays below the row's count.
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> ({1'b0, idx_q} < row_cnt_q))
    else $error("flush index ran past the row count");

  // A flush starts at channel zero.
  a_flush_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flush_q) |-> idx_q == '0)
    else $error("flush did not start at channel zero");

  // A clear leaves the head cell empty.
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> chain[0] == SlotEmpty)
    else $error("head cell not empty after clear");

endmodule
